/* hdl/i2cbc_pkg.sv */
// Package for the I2C bus-clear sequencer: phase codes, register indexes, state,
// configuration, request and result types, and configuration reset values. No dependencies.
package i2cbc_pkg;

    localparam int unsigned HALF_PERIOD_W = 16;
    localparam int unsigned PULSE_CNT_W   = 4;
    localparam int unsigned CFG_DATA_W    = 16;
    localparam int unsigned CFG_INDEX_W   = 1;
    localparam int unsigned PHASE_W       = 3;

    localparam logic [HALF_PERIOD_W-1:0] HALF_PERIOD_RESET = 16'd5;
    localparam logic [PULSE_CNT_W-1:0]   PULSE_COUNT_RESET = 4'd9;

    // configuration register indexes
    localparam logic [CFG_INDEX_W-1:0] REG_HALF_PERIOD = 1'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_PULSE_COUNT = 1'd1;

    // sequencer phases
    localparam logic [PHASE_W-1:0] PH_IDLE     = 3'd0;
    localparam logic [PHASE_W-1:0] PH_SETTLE   = 3'd1;
    localparam logic [PHASE_W-1:0] PH_LOW      = 3'd2;
    localparam logic [PHASE_W-1:0] PH_HIGH     = 3'd3;
    localparam logic [PHASE_W-1:0] PH_STOP_SDA = 3'd4;
    localparam logic [PHASE_W-1:0] PH_STOP_SCL = 3'd5;
    localparam logic [PHASE_W-1:0] PH_STOP_REL = 3'd6;

    typedef struct packed {
        logic [PHASE_W-1:0]       phase;
        logic [PULSE_CNT_W-1:0]   pulses_done;
        logic [HALF_PERIOD_W-1:0] phase_timer;
        logic                     forced;
        logic                     held_flag;
    } seq_state_t;

    typedef struct packed {
        logic [HALF_PERIOD_W-1:0] half_period_ticks;
        logic [PULSE_CNT_W-1:0]   pulse_count;
    } seq_cfg_t;

    typedef struct packed {
        logic kind;
        logic force_clock;
        logic sda_level;
        logic scl_level;
    } seq_req_t;

    typedef struct packed {
        logic scl_pull_low;
        logic sda_pull_low;
        logic busy_res;
        logic finished;
        logic sda_free;
        logic scl_held;
    } seq_res_t;

endpackage

/* hdl/i2cbc_ifs.sv */
// Valid/ready channel interfaces for the I2C bus-clear sequencer:
// the request channel and the result channel. No dependencies.
interface i2cbc_in_if;
    logic valid;
    logic ready;
    logic kind;
    logic force_clock;
    logic sda_level;
    logic scl_level;

    modport source (output valid, output kind, output force_clock, output sda_level,
                    output scl_level, input ready);
    modport sink   (input valid, input kind, input force_clock, input sda_level,
                    input scl_level, output ready);
endinterface

interface i2cbc_out_if;
    logic valid;
    logic ready;
    logic scl_pull_low;
    logic sda_pull_low;
    logic busy_res;
    logic finished;
    logic sda_free;
    logic scl_held;

    modport source (output valid, output scl_pull_low, output sda_pull_low,
                    output busy_res, output finished, output sda_free,
                    output scl_held, input ready);
    modport sink   (input valid, input scl_pull_low, input sda_pull_low,
                    input busy_res, input finished, input sda_free,
                    input scl_held, output ready);
endinterface

/* hdl/i2cbc_step.sv */
// Next-state and result logic for one request of the bus-clear sequencer.
// Depends on i2cbc_pkg.
module i2cbc_step (
    input  i2cbc_pkg::seq_state_t cur,
    input  i2cbc_pkg::seq_cfg_t   cfg,
    input  i2cbc_pkg::seq_req_t   req,
    output i2cbc_pkg::seq_state_t nxt,
    output i2cbc_pkg::seq_res_t   res
);

    logic [i2cbc_pkg::HALF_PERIOD_W-1:0] limit;
    logic [i2cbc_pkg::HALF_PERIOD_W:0]   timer_inc;
    logic                                ends;
    logic [i2cbc_pkg::PULSE_CNT_W-1:0]   pulses_inc;
    logic                                pulses_left;
    logic                                clock_needed;

    always_comb
    begin
        // half period of zero counts as one tick
        limit = (cfg.half_period_ticks == '0) ? i2cbc_pkg::HALF_PERIOD_W'(1)
                                              : cfg.half_period_ticks;
        timer_inc    = {1'b0, cur.phase_timer} + (i2cbc_pkg::HALF_PERIOD_W + 1)'(1);
        ends         = (timer_inc >= {1'b0, limit});
        pulses_inc   = cur.pulses_done + i2cbc_pkg::PULSE_CNT_W'(1);
        pulses_left  = (cur.phase == i2cbc_pkg::PH_HIGH) ? (pulses_inc < cfg.pulse_count)
                                                         : (cur.pulses_done < cfg.pulse_count);
        clock_needed = cur.forced || (!req.sda_level && req.scl_level);

        nxt = cur;
        res = '0;

        if (cur.phase == i2cbc_pkg::PH_IDLE)
        begin
            if (req.kind)
            begin
                nxt.forced      = req.force_clock;
                nxt.held_flag   = 1'b0;
                nxt.pulses_done = '0;
                nxt.phase_timer = '0;
                nxt.phase       = i2cbc_pkg::PH_SETTLE;
            end
        end
        else
        begin
            nxt.phase_timer = ends ? '0 : timer_inc[i2cbc_pkg::HALF_PERIOD_W-1:0];
            if (ends)
            begin
                unique case (cur.phase)
                    i2cbc_pkg::PH_SETTLE, i2cbc_pkg::PH_HIGH:
                    begin
                        if (cur.phase == i2cbc_pkg::PH_HIGH)
                            nxt.pulses_done = pulses_inc;
                        if (cur.phase == i2cbc_pkg::PH_SETTLE && !clock_needed)
                        begin
                            nxt.phase    = i2cbc_pkg::PH_IDLE;
                            res.finished = 1'b1;
                            res.sda_free = req.sda_level;
                        end
                        else if (!pulses_left)
                            nxt.phase = i2cbc_pkg::PH_STOP_SDA;
                        else if (req.scl_level)
                            nxt.phase = i2cbc_pkg::PH_LOW;
                        else
                        begin
                            // device stretching SCL: give up clocking, still send STOP
                            nxt.held_flag = 1'b1;
                            nxt.phase     = i2cbc_pkg::PH_STOP_SDA;
                        end
                    end
                    i2cbc_pkg::PH_LOW:      nxt.phase = i2cbc_pkg::PH_HIGH;
                    i2cbc_pkg::PH_STOP_SDA: nxt.phase = i2cbc_pkg::PH_STOP_SCL;
                    i2cbc_pkg::PH_STOP_SCL: nxt.phase = i2cbc_pkg::PH_STOP_REL;
                    default:
                    begin
                        nxt.phase    = i2cbc_pkg::PH_IDLE;
                        res.finished = 1'b1;
                        res.sda_free = req.sda_level;
                        res.scl_held = cur.held_flag;
                    end
                endcase
            end
        end

        res.scl_pull_low = (nxt.phase == i2cbc_pkg::PH_LOW);
        res.sda_pull_low = (nxt.phase == i2cbc_pkg::PH_STOP_SDA) ||
                           (nxt.phase == i2cbc_pkg::PH_STOP_SCL);
        res.busy_res     = (nxt.phase != i2cbc_pkg::PH_IDLE);
    end

endmodule

/* hdl/i2c_bus_clear_sequencer_core.sv */
// I2C bus-clear sequencer top level. Depends on i2cbc_pkg, i2cbc_ifs, i2cbc_step.
// An accepted request's result goes into the output register, or into the skid register while the output is stalled.
// Throughput: one request per cycle while ready is high; the state update is a single registered pass.
// An output register plus a skid register hold results; ready falls only when both are full.
// Reset (rst_n low, asynchronous): sequencer idle, no results held,
// half_period_ticks = 5, pulse_count = 9.
module i2c_bus_clear_sequencer_core (
    input  logic                                clk,
    input  logic                                rst_n,
    i2cbc_in_if.sink                            in_ch,
    i2cbc_out_if.source                         out_ch,
    input  logic                                cfg_we,
    input  logic [i2cbc_pkg::CFG_INDEX_W-1:0]   cfg_index,
    input  logic [i2cbc_pkg::CFG_DATA_W-1:0]    cfg_data
);

    i2cbc_pkg::seq_cfg_t   cfg_reg;
    i2cbc_pkg::seq_state_t state_reg;
    i2cbc_pkg::seq_state_t state_next;
    i2cbc_pkg::seq_req_t   req;
    i2cbc_pkg::seq_res_t   res_next;
    i2cbc_pkg::seq_res_t   out_data_reg;
    i2cbc_pkg::seq_res_t   skid_data_reg;
    logic                  out_valid_reg;
    logic                  skid_valid_reg;
    logic                  in_fire;
    logic                  out_free;

    assign req = '{kind:        in_ch.kind,
                   force_clock: in_ch.force_clock,
                   sda_level:   in_ch.sda_level,
                   scl_level:   in_ch.scl_level};

    assign in_ch.ready = !skid_valid_reg;
    assign in_fire     = in_ch.valid && !skid_valid_reg;
    assign out_free    = !out_valid_reg || out_ch.ready;

    i2cbc_step u_step (
        .cur (state_reg),
        .cfg (cfg_reg),
        .req (req),
        .nxt (state_next),
        .res (res_next)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.half_period_ticks <= i2cbc_pkg::HALF_PERIOD_RESET;
            cfg_reg.pulse_count       <= i2cbc_pkg::PULSE_COUNT_RESET;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                i2cbc_pkg::REG_HALF_PERIOD:
                    cfg_reg.half_period_ticks <= cfg_data;
                default:
                    cfg_reg.pulse_count <= cfg_data[i2cbc_pkg::PULSE_CNT_W-1:0];
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg.phase       <= i2cbc_pkg::PH_IDLE;
            state_reg.pulses_done <= '0;
            state_reg.phase_timer <= '0;
            state_reg.forced      <= 1'b0;
            state_reg.held_flag   <= 1'b0;
        end
        else if (in_fire)
        begin
            state_reg <= state_next;
        end
    end

    // result path: output register with a skid register behind it
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else if (out_free)
        begin
            if (skid_valid_reg)
            begin
                out_valid_reg  <= 1'b1;
                skid_valid_reg <= 1'b0;
            end
            else
            begin
                out_valid_reg <= in_fire;
            end
        end
        else if (in_fire)
        begin
            skid_valid_reg <= 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (out_free)
        begin
            if (skid_valid_reg)
                out_data_reg <= skid_data_reg;
            else if (in_fire)
                out_data_reg <= res_next;
        end
        else if (in_fire)
        begin
            skid_data_reg <= res_next;
        end
    end

    assign out_ch.valid        = out_valid_reg;
    assign out_ch.scl_pull_low = out_data_reg.scl_pull_low;
    assign out_ch.sda_pull_low = out_data_reg.sda_pull_low;
    assign out_ch.busy_res     = out_data_reg.busy_res;
    assign out_ch.finished     = out_data_reg.finished;
    assign out_ch.sda_free     = out_data_reg.sda_free;
    assign out_ch.scl_held     = out_data_reg.scl_held;

endmodule

/* hdl/i2cbc_checker.sv */
// Port-level checks for the I2C bus-clear sequencer, bound to
// i2c_bus_clear_sequencer_core. No package dependency.
module i2cbc_checker (
    input logic clk,
    input logic rst_n,
    input logic in_ready,
    input logic out_valid,
    input logic out_ready,
    input logic scl_pull_low,
    input logic sda_pull_low,
    input logic busy_res,
    input logic finished,
    input logic sda_free,
    input logic scl_held
);

    // a completed sequence leaves the sequencer idle
    a_finish_idle: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && finished |-> !busy_res)
        else $error("finished result still busy");

    // completion status only appears with finished
    a_status_on_finish: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (sda_free || scl_held) |-> finished)
        else $error("completion status without finished");

    // a line is only driven during a sequence, and never both at once
    a_drive_busy: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (scl_pull_low || sda_pull_low) |-> busy_res && !(scl_pull_low && sda_pull_low))
        else $error("illegal line drive");

    // a stalled result stays offered
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid)
        else $error("result dropped while stalled");

    // after a stall with ready low the skid empties as soon as the output drains
    a_ready_back: assert property (@(posedge clk) disable iff (!rst_n)
        !in_ready && out_ready |=> in_ready)
        else $error("request side stuck after output drained");

endmodule

bind i2c_bus_clear_sequencer_core i2cbc_checker u_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_ready     (in_ch.ready),
    .out_valid    (out_ch.valid),
    .out_ready    (out_ch.ready),
    .scl_pull_low (out_ch.scl_pull_low),
    .sda_pull_low (out_ch.sda_pull_low),
    .busy_res     (out_ch.busy_res),
    .finished     (out_ch.finished),
    .sda_free     (out_ch.sda_free),
    .scl_held     (out_ch.scl_held)
);
